### design/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
// Depends on nothing; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("scheduler assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### design/tsch_pkg.sv
// Shared types and constants of the three-class task scheduler.
// Used by the controller, the datapath, the slot FIFO and the top level.
package tsch_pkg;

  localparam int MAX_TASKS = 8;
  localparam int TICK_BITS = 16;
  localparam int SLOT_W    = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int ID_W      = 8;
  localparam logic [SLOT_W-1:0] IDX_LAST = SLOT_W'(MAX_TASKS - 1);

  typedef enum logic [2:0] {
    ACT_START      = 3'd0,
    ACT_CREATE_SYS = 3'd1,
    ACT_CREATE_PER = 3'd2,
    ACT_CREATE_RR  = 3'd3,
    ACT_TICK       = 3'd4,
    ACT_YIELD      = 3'd5,
    ACT_TERM       = 3'd6,
    ACT_NONE       = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ST_DEAD    = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2
  } slot_status_t;

  typedef enum logic [1:0] {
    CL_SYSTEM   = 2'd0,
    CL_PERIODIC = 2'd1,
    CL_RR       = 2'd2
  } task_class_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_FULL     = 2'd1,
    ERR_BUDGET   = 2'd2,
    ERR_CONFLICT = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRE,
    S_SCAN,
    S_FINISH,
    S_DISP,
    S_CREATE,
    S_RESP
  } fsm_state_t;

  typedef struct packed {
    logic              accept;
    logic              pre;
    logic              scan;
    logic              finish;
    logic              disp;
    logic              create;
    logic              resp;
    logic [SLOT_W-1:0] idx;
  } tsch_cmd_t;

  typedef struct packed {
    action_t action;
    logic    started;
    logic    need_disp;
    logic    out_free;
  } tsch_sts_t;

endpackage

### design/tsch_fifo.sv
// Circular queue of slot numbers, one per task class that waits in order.
// Depends on tsch_pkg.
module tsch_fifo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [tsch_pkg::SLOT_W-1:0] push_data,
  input  logic                       pop,
  output logic [tsch_pkg::SLOT_W-1:0] head_data,
  output logic                       not_empty
);

  logic [tsch_pkg::SLOT_W-1:0] item_r [tsch_pkg::MAX_TASKS];
  logic [tsch_pkg::SLOT_W-1:0] head_r, head_nxt;
  logic [tsch_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [tsch_pkg::CNT_W:0]    tail_sum;
  logic [tsch_pkg::SLOT_W-1:0] tail;
  logic                        do_push;

  assign tail_sum = (tsch_pkg::CNT_W+1)'(head_r) + (tsch_pkg::CNT_W+1)'(cnt_r);
  assign tail = (tail_sum >= (tsch_pkg::CNT_W+1)'(tsch_pkg::MAX_TASKS)) ?
                tsch_pkg::SLOT_W'(tail_sum - (tsch_pkg::CNT_W+1)'(tsch_pkg::MAX_TASKS)) :
                tsch_pkg::SLOT_W'(tail_sum);
  // drop a push into a full queue
  assign do_push   = push && (cnt_r < tsch_pkg::CNT_W'(tsch_pkg::MAX_TASKS));
  assign head_data = item_r[head_r];
  assign not_empty = (cnt_r != '0);

  always_comb begin
    head_nxt = head_r;
    cnt_nxt  = cnt_r;
    if (pop && not_empty) begin
      head_nxt = (head_r == tsch_pkg::IDX_LAST) ? '0 : head_r + 1'b1;
      cnt_nxt  = cnt_r - 1'b1;
    end else if (do_push) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push && !pop) begin
      item_r[tail] <= push_data;
    end
  end

endmodule

### design/tsch_ctrl.sv
// Sequencer of the scheduler: walks each kernel request through its steps.
// Depends on tsch_pkg; drives the datapath by command, reads its status.
module tsch_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tsch_pkg::tsch_sts_t sts,
  output tsch_pkg::tsch_cmd_t cmd
);

  tsch_pkg::fsm_state_t        state_r, state_nxt;
  logic [tsch_pkg::SLOT_W-1:0] idx_r, idx_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tsch_pkg::S_IDLE: begin
        if (in_valid) state_nxt = tsch_pkg::S_PRE;
      end
      tsch_pkg::S_PRE: begin
        unique case (sts.action) inside
          tsch_pkg::ACT_START:
            state_nxt = sts.started ? tsch_pkg::S_RESP : tsch_pkg::S_SCAN;
          tsch_pkg::ACT_CREATE_SYS, tsch_pkg::ACT_CREATE_PER, tsch_pkg::ACT_CREATE_RR:
            state_nxt = sts.started ? tsch_pkg::S_SCAN : tsch_pkg::S_CREATE;
          tsch_pkg::ACT_TICK, tsch_pkg::ACT_YIELD, tsch_pkg::ACT_TERM:
            state_nxt = sts.started ? tsch_pkg::S_SCAN : tsch_pkg::S_RESP;
          default:
            state_nxt = tsch_pkg::S_RESP;
        endcase
      end
      tsch_pkg::S_SCAN: begin
        if (idx_r == tsch_pkg::IDX_LAST) begin
          unique case (sts.action) inside
            tsch_pkg::ACT_START:
              state_nxt = tsch_pkg::S_DISP;
            tsch_pkg::ACT_CREATE_SYS, tsch_pkg::ACT_CREATE_PER, tsch_pkg::ACT_CREATE_RR:
              state_nxt = tsch_pkg::S_CREATE;
            default:
              state_nxt = tsch_pkg::S_FINISH;
          endcase
        end
      end
      tsch_pkg::S_FINISH: begin
        state_nxt = sts.need_disp ? tsch_pkg::S_DISP : tsch_pkg::S_RESP;
      end
      tsch_pkg::S_DISP:   state_nxt = tsch_pkg::S_RESP;
      tsch_pkg::S_CREATE: state_nxt = tsch_pkg::S_RESP;
      tsch_pkg::S_RESP: begin
        // hold until the result register is free
        if (sts.out_free) state_nxt = tsch_pkg::S_IDLE;
      end
      default: state_nxt = tsch_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    idx_nxt = '0;
    if (state_r == tsch_pkg::S_SCAN && idx_r != tsch_pkg::IDX_LAST) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.idx    = idx_r;
    unique case (state_r)
      tsch_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      tsch_pkg::S_PRE:    cmd.pre    = 1'b1;
      tsch_pkg::S_SCAN:   cmd.scan   = 1'b1;
      tsch_pkg::S_FINISH: cmd.finish = 1'b1;
      tsch_pkg::S_DISP:   cmd.disp   = 1'b1;
      tsch_pkg::S_CREATE: cmd.create = 1'b1;
      tsch_pkg::S_RESP:   cmd.resp   = sts.out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsch_pkg::S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

### design/tsch_dp.sv
// Datapath of the scheduler: slot table, class queues, tick and result register.
// Depends on tsch_pkg and tsch_fifo; stepped by tsch_ctrl commands.
module tsch_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  tsch_pkg::tsch_cmd_t cmd,
  output tsch_pkg::tsch_sts_t sts,
  input  logic [2:0]          in_action,
  input  logic [15:0]         in_task_period,
  input  logic [15:0]         in_task_budget,
  input  logic [15:0]         in_task_offset,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_running_slot,
  output logic                out_running_idle,
  output logic [7:0]          out_new_task_id,
  output logic [1:0]          out_error_code
);

  localparam int TW = tsch_pkg::TICK_BITS;
  localparam int SW = tsch_pkg::SLOT_W;
  localparam int MT = tsch_pkg::MAX_TASKS;

  // request registers
  tsch_pkg::action_t     act_r;
  logic [TW-1:0]         per_r, bud_r, off_r;

  // scheduler state
  tsch_pkg::slot_status_t st_r   [MT];
  tsch_pkg::task_class_t  cls_r  [MT];
  logic [TW-1:0]          sper_r [MT];
  logic [TW-1:0]          sbud_r [MT];
  logic [TW-1:0]          srel_r [MT];
  logic [TW-1:0]          tick_r;
  logic                   started_r;
  logic [SW-1:0]          cur_r;
  logic                   idle_r;
  logic [tsch_pkg::ID_W-1:0] last_id_r;
  logic [tsch_pkg::CNT_W-1:0] live_r;

  // per-request working state
  tsch_pkg::err_t        err_r;
  logic [tsch_pkg::ID_W-1:0] new_id_r;
  logic [1:0]            rdy_cnt_r;
  logic [MT-1:0]         pvec_r;

  // result register
  logic                  out_valid_r;
  logic [2:0]            o_slot_r;
  logic                  o_idle_r;
  logic [7:0]            o_id_r;
  tsch_pkg::err_t        o_err_r;

  // one read port into the slot table
  logic [SW-1:0]          rd_idx;
  tsch_pkg::slot_status_t rd_st;
  tsch_pkg::task_class_t  rd_cls;
  logic [TW-1:0]          rd_per, rd_bud, rd_rel, rel_adv, diff, diff_adv;
  logic                   is_per, nonneg, upd, pv;

  logic [SW-1:0]          free_idx, rdy_pick, pick;
  logic                   free_found, any_ready, found;
  tsch_pkg::task_class_t  new_cls;
  logic                   bud_bad, tbl_full, create_ok;
  logic                   term_cur, requeue;
  logic [tsch_pkg::ID_W-1:0] id_inc, id_next;

  logic [SW-1:0]          sys_head, rr_head;
  logic                   sys_nempty, rr_nempty;
  logic                   sys_push, sys_pop, rr_push, rr_pop;

  assign rd_idx   = cmd.scan ? cmd.idx : cur_r;
  assign rd_st    = st_r[rd_idx];
  assign rd_cls   = cls_r[rd_idx];
  assign rd_per   = sper_r[rd_idx];
  assign rd_bud   = sbud_r[rd_idx];
  assign rd_rel   = srel_r[rd_idx];
  assign rel_adv  = rd_rel + rd_per;
  assign diff     = tick_r - rd_rel;
  assign diff_adv = diff - rd_per;
  assign nonneg   = !diff[TW-1];
  assign is_per   = (rd_cls == tsch_pkg::CL_PERIODIC);
  // push an overrunning periodic task one period ahead; not on start scans
  assign upd = (act_r != tsch_pkg::ACT_START) && (rd_st == tsch_pkg::ST_READY) &&
               is_per && nonneg && (diff > rd_bud) && (diff < rd_per);
  // readiness is taken against the advanced release when one was made
  assign pv  = is_per && (upd ? !diff_adv[TW-1] : nonneg);

  assign term_cur = (act_r == tsch_pkg::ACT_TERM) && !idle_r;
  assign requeue  = !term_cur && !idle_r && (rd_cls != tsch_pkg::CL_SYSTEM);

  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = MT - 1; i >= 0; i--) begin
      if (st_r[i] == tsch_pkg::ST_DEAD) begin
        free_idx   = SW'(i);
        free_found = 1'b1;
      end
    end
  end

  always_comb begin
    rdy_pick  = '0;
    any_ready = 1'b0;
    for (int i = 0; i < MT; i++) begin
      if (st_r[i] == tsch_pkg::ST_READY && pvec_r[i]) begin
        rdy_pick  = SW'(i);
        any_ready = 1'b1;
      end
    end
  end

  always_comb begin
    unique case (act_r)
      tsch_pkg::ACT_CREATE_PER: new_cls = tsch_pkg::CL_PERIODIC;
      tsch_pkg::ACT_CREATE_RR:  new_cls = tsch_pkg::CL_RR;
      default:                  new_cls = tsch_pkg::CL_SYSTEM;
    endcase
  end

  assign bud_bad   = (new_cls == tsch_pkg::CL_PERIODIC) && (bud_r >= per_r);
  assign tbl_full  = (live_r >= tsch_pkg::CNT_W'(MT)) || !free_found;
  assign create_ok = !bud_bad && !tbl_full;
  assign id_inc    = last_id_r + 1'b1;
  assign id_next   = (id_inc == '0) ? tsch_pkg::ID_W'(1) : id_inc;

  assign found = sys_nempty || any_ready || rr_nempty;
  assign pick  = sys_nempty ? sys_head : (any_ready ? rdy_pick : rr_head);

  assign sys_push = cmd.create && create_ok && (new_cls == tsch_pkg::CL_SYSTEM);
  assign rr_push  = (cmd.create && create_ok && (new_cls == tsch_pkg::CL_RR)) ||
                    (cmd.finish && requeue && (rd_cls == tsch_pkg::CL_RR));
  assign sys_pop  = cmd.disp && sys_nempty;
  assign rr_pop   = cmd.disp && !sys_nempty && !any_ready && rr_nempty;

  tsch_fifo u_sys_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (sys_push),
    .push_data (free_idx),
    .pop       (sys_pop),
    .head_data (sys_head),
    .not_empty (sys_nempty)
  );

  tsch_fifo u_rr_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rr_push),
    .push_data (cmd.finish ? cur_r : free_idx),
    .pop       (rr_pop),
    .head_data (rr_head),
    .not_empty (rr_nempty)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MT; i++) st_r[i] <= tsch_pkg::ST_DEAD;
      tick_r      <= '0;
      started_r   <= 1'b0;
      cur_r       <= '0;
      idle_r      <= 1'b1;
      last_id_r   <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.pre) begin
        if (act_r == tsch_pkg::ACT_START) begin
          tick_r    <= '0;
          started_r <= 1'b1;
        end else if (act_r == tsch_pkg::ACT_TICK && started_r) begin
          tick_r <= tick_r + 1'b1;
        end
      end
      if (cmd.finish) begin
        if (term_cur) begin
          st_r[cur_r] <= tsch_pkg::ST_DEAD;
          if (live_r != '0) live_r <= live_r - 1'b1;
        end else if (requeue) begin
          st_r[cur_r] <= tsch_pkg::ST_READY;
        end
      end
      if (cmd.disp) begin
        if (found) begin
          cur_r      <= pick;
          idle_r     <= 1'b0;
          st_r[pick] <= tsch_pkg::ST_RUNNING;
        end else begin
          cur_r  <= '0;
          idle_r <= 1'b1;
        end
      end
      if (cmd.create && create_ok) begin
        st_r[free_idx] <= tsch_pkg::ST_READY;
        live_r         <= live_r + 1'b1;
        last_id_r      <= id_next;
      end
      if (cmd.resp) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: request, slot fields, working state and result
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r     <= tsch_pkg::action_t'(in_action);
      per_r     <= in_task_period[TW-1:0];
      bud_r     <= in_task_budget[TW-1:0];
      off_r     <= in_task_offset[TW-1:0];
      err_r     <= tsch_pkg::ERR_NONE;
      new_id_r  <= '0;
      rdy_cnt_r <= '0;
    end
    if (cmd.pre && act_r == tsch_pkg::ACT_YIELD && started_r && !idle_r && is_per) begin
      srel_r[cur_r] <= rel_adv;
    end
    if (cmd.scan) begin
      if (upd) srel_r[cmd.idx] <= rel_adv;
      pvec_r[cmd.idx] <= pv;
      if (rd_st == tsch_pkg::ST_READY && pv && rdy_cnt_r != 2'd2) begin
        rdy_cnt_r <= rdy_cnt_r + 1'b1;
      end
    end
    if (cmd.finish && rdy_cnt_r == 2'd2) begin
      err_r <= tsch_pkg::ERR_CONFLICT;
    end
    if (cmd.create) begin
      if (bud_bad) begin
        err_r <= tsch_pkg::ERR_BUDGET;
      end else if (tbl_full) begin
        err_r <= tsch_pkg::ERR_FULL;
      end else begin
        err_r    <= (rdy_cnt_r == 2'd2) ? tsch_pkg::ERR_CONFLICT : tsch_pkg::ERR_NONE;
        new_id_r <= id_next;
        cls_r[free_idx] <= new_cls;
        if (new_cls == tsch_pkg::CL_PERIODIC) begin
          sper_r[free_idx] <= per_r;
          sbud_r[free_idx] <= bud_r;
          srel_r[free_idx] <= off_r;
        end else begin
          sper_r[free_idx] <= '0;
          sbud_r[free_idx] <= '0;
          srel_r[free_idx] <= '0;
        end
      end
    end
    if (cmd.resp) begin
      o_slot_r <= idle_r ? 3'd0 : 3'(cur_r);
      o_idle_r <= idle_r;
      o_id_r   <= 8'(new_id_r);
      o_err_r  <= err_r;
    end
  end

  assign sts.action    = act_r;
  assign sts.started   = started_r;
  assign sts.need_disp = term_cur || idle_r || (rd_cls != tsch_pkg::CL_SYSTEM);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_running_slot = o_slot_r;
  assign out_running_idle = o_idle_r;
  assign out_new_task_id  = o_id_r;
  assign out_error_code   = o_err_r;

endmodule

### design/three_class_task_scheduler.sv
// Three-class task scheduler: one kernel request in, one status result out.
// Request channel (in_valid/in_ready): action plus period, budget and offset
// of a periodic task to create. Result channel (out_valid/out_ready): running
// slot, idle flag, new task identifier and error code.
// Each request runs through a sequencer: one decode step, where the action
// needs it a scan of the slot table at one slot per cycle, then requeue,
// dispatch or task creation, and the result. A new request is taken in the
// cycle after the result is loaded, not while the last one is in the sequencer.
// The result sits in an output register; a new request is accepted while it
// waits, and a stalled receiver holds the sequencer in its last step.
// Reset (rst_n low, synchronous) kills all slots, empties both queues,
// clears the tick, identifier and live counters and makes idle run.
// Depends on tsch_pkg, tsch_ctrl, tsch_dp, tsch_fifo and assert_macros.svh.
`include "assert_macros.svh"
module three_class_task_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [15:0] in_task_period,
  input  logic [15:0] in_task_budget,
  input  logic [15:0] in_task_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_running_slot,
  output logic        out_running_idle,
  output logic [7:0]  out_new_task_id,
  output logic [1:0]  out_error_code
);

  tsch_pkg::tsch_cmd_t cmd;
  tsch_pkg::tsch_sts_t sts;

  tsch_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tsch_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_action        (in_action),
    .in_task_period   (in_task_period),
    .in_task_budget   (in_task_budget),
    .in_task_offset   (in_task_offset),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_running_slot (out_running_slot),
    .out_running_idle (out_running_idle),
    .out_new_task_id  (out_new_task_id),
    .out_error_code   (out_error_code)
  );

  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `ASSERT_HOLDS(a_one_step, clk, rst_n,
    $onehot0({cmd.pre, cmd.scan, cmd.finish, cmd.disp, cmd.create, cmd.resp}))
  `ASSERT_IMPLIES(a_idle_slot_zero, clk, rst_n, out_valid && out_running_idle,
    out_running_slot == 3'd0)
  `ASSERT_IMPLIES(a_result_loaded, clk, rst_n, $rose(out_valid), $past(cmd.resp))

endmodule

### sim/tb_three_class_task_scheduler.sv
// Testbench for the three-class task scheduler: directed and random kernel requests.
// Depends on tsch_pkg and three_class_task_scheduler; predicts every status result.
`timescale 1ns / 100ps
module tb_three_class_task_scheduler;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_action = tsch_pkg::ACT_NONE;
  logic [15:0] in_task_period = '0;
  logic [15:0] in_task_budget = '0;
  logic [15:0] in_task_offset = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_running_slot;
  logic        out_running_idle;
  logic [7:0]  out_new_task_id;
  logic [1:0]  out_error_code;

  three_class_task_scheduler dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct packed {
    logic [2:0] slot;
    logic       idle;
    logic [7:0] ident;
    logic [1:0] err;
  } status_t;

  status_t status_q[$];
  int      errors = 0;

  // scheduler shadow
  tsch_pkg::slot_status_t sh_status[tsch_pkg::MAX_TASKS];
  tsch_pkg::task_class_t  sh_class[tsch_pkg::MAX_TASKS];
  logic [15:0]  sh_period[tsch_pkg::MAX_TASKS];
  logic [15:0]  sh_budget[tsch_pkg::MAX_TASKS];
  logic [15:0]  sh_release[tsch_pkg::MAX_TASKS];
  logic [2:0]   sys_q[$];
  logic [2:0]   rr_q[$];
  logic [15:0]  sh_tick;
  logic [7:0]   sh_ident;
  int           sh_live;
  logic         sh_idle;
  logic [2:0]   sh_cur;
  logic         sh_started;

  function automatic bit per_ready(int i);
    logic [15:0] d;
    d = sh_tick - sh_release[i];
    return sh_status[i] == tsch_pkg::ST_READY && sh_class[i] == tsch_pkg::CL_PERIODIC &&
           !d[15];
  endfunction

  function automatic bit advance_overruns();
    int n;
    logic [15:0] d;
    n = 0;
    for (int i = 0; i < tsch_pkg::MAX_TASKS; i++) begin
      if (sh_status[i] == tsch_pkg::ST_READY && sh_class[i] == tsch_pkg::CL_PERIODIC) begin
        d = sh_tick - sh_release[i];
        if (!d[15] && d > sh_budget[i] && d < sh_period[i])
          sh_release[i] = sh_release[i] + sh_period[i];
      end
      if (per_ready(i)) n++;
    end
    return n > 1;
  endfunction

  function automatic void pick_next();
    bit found;
    logic [2:0] p;
    found = 0;
    p = 3'd0;
    if (sys_q.size() > 0) begin
      p = sys_q.pop_front();
      found = 1;
    end else begin
      for (int i = 0; i < tsch_pkg::MAX_TASKS; i++)
        if (per_ready(i)) begin
          p = 3'(i);
          found = 1;
        end
    end
    if (!found && rr_q.size() > 0) begin
      p = rr_q.pop_front();
      found = 1;
    end
    sh_idle = !found;
    sh_cur = found ? p : 3'd0;
    if (found) sh_status[p] = tsch_pkg::ST_RUNNING;
  endfunction

  function automatic logic [1:0] create_task(tsch_pkg::task_class_t c, logic [15:0] per,
                                             logic [15:0] bud, logic [15:0] off,
                                             output logic [7:0] id);
    int x;
    id = 8'd0;
    if (c == tsch_pkg::CL_PERIODIC) begin
      if (bud >= per) return tsch_pkg::ERR_BUDGET;
    end else begin
      per = 16'd0; bud = 16'd0; off = 16'd0;
    end
    if (sh_live >= tsch_pkg::MAX_TASKS) return tsch_pkg::ERR_FULL;
    x = -1;
    for (int i = tsch_pkg::MAX_TASKS - 1; i >= 0; i--)
      if (sh_status[i] == tsch_pkg::ST_DEAD) x = i;
    if (x < 0) return tsch_pkg::ERR_FULL;
    sh_live++;
    sh_ident = sh_ident + 1'b1;
    if (sh_ident == 8'd0) sh_ident = 8'd1;
    sh_status[x] = tsch_pkg::ST_READY;
    sh_class[x] = c;
    sh_period[x] = per;
    sh_budget[x] = bud;
    sh_release[x] = off;
    if (c == tsch_pkg::CL_SYSTEM && sys_q.size() < tsch_pkg::MAX_TASKS)
      sys_q.push_back(3'(x));
    if (c == tsch_pkg::CL_RR && rr_q.size() < tsch_pkg::MAX_TASKS)
      rr_q.push_back(3'(x));
    id = sh_ident;
    return tsch_pkg::ERR_NONE;
  endfunction

  function automatic status_t predict_status(logic [2:0] act, logic [15:0] per,
                                             logic [15:0] bud, logic [15:0] off);
    status_t r;
    bit conf;
    logic [1:0] e;
    logic [7:0] id;
    e = tsch_pkg::ERR_NONE;
    id = 8'd0;
    if (act == tsch_pkg::ACT_START) begin
      sh_tick = 16'd0;
      if (!sh_started) begin
        sh_started = 1'b1;
        pick_next();
      end
    end else if (act >= tsch_pkg::ACT_CREATE_SYS && act <= tsch_pkg::ACT_CREATE_RR) begin
      conf = sh_started ? advance_overruns() : 1'b0;
      e = create_task(tsch_pkg::task_class_t'(2'(act - 3'd1)), per, bud, off, id);
      if (e == tsch_pkg::ERR_NONE && conf) e = tsch_pkg::ERR_CONFLICT;
    end else if (act >= tsch_pkg::ACT_TICK && act <= tsch_pkg::ACT_TERM && sh_started) begin
      if (act == tsch_pkg::ACT_TICK) sh_tick = sh_tick + 1'b1;
      if (act == tsch_pkg::ACT_YIELD && !sh_idle && sh_class[sh_cur] == tsch_pkg::CL_PERIODIC)
        sh_release[sh_cur] = sh_release[sh_cur] + sh_period[sh_cur];
      if (advance_overruns()) e = tsch_pkg::ERR_CONFLICT;
      if (act == tsch_pkg::ACT_TERM && !sh_idle) begin
        sh_status[sh_cur] = tsch_pkg::ST_DEAD;
        if (sh_live > 0) sh_live--;
        pick_next();
      end else if (sh_idle || sh_class[sh_cur] != tsch_pkg::CL_SYSTEM) begin
        if (!sh_idle) begin
          sh_status[sh_cur] = tsch_pkg::ST_READY;
          if (sh_class[sh_cur] == tsch_pkg::CL_RR && rr_q.size() < tsch_pkg::MAX_TASKS)
            rr_q.push_back(sh_cur);
        end
        pick_next();
      end
    end
    r.slot = sh_idle ? 3'd0 : sh_cur;
    r.idle = sh_idle;
    r.ident = id;
    r.err = e;
    return r;
  endfunction

  initial begin
    for (int i = 0; i < tsch_pkg::MAX_TASKS; i++) begin
      sh_status[i] = tsch_pkg::ST_DEAD;
      sh_class[i] = tsch_pkg::CL_SYSTEM;
      sh_period[i] = 16'd0;
      sh_budget[i] = 16'd0;
      sh_release[i] = 16'd0;
    end
    sh_tick = 16'd0;
    sh_ident = 8'd0;
    sh_live = 0;
    sh_idle = 1'b1;
    sh_cur = 3'd0;
    sh_started = 1'b0;
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic send_request(logic [2:0] act, logic [15:0] per = 0,
                              logic [15:0] bud = 0, logic [15:0] off = 0);
    int gap;
    gap = $urandom_range(0, 7);
    // with no gap, valid stays high into the next request
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_task_period <= per;
    in_task_budget <= bud;
    in_task_offset <= off;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    status_q.push_back(predict_status(act, per, bud, off));
  endtask

  // receiver: random stall per result, then compare
  initial begin
    status_t w;
    int stall;
    @(posedge rst_n);
    forever begin
      stall = $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (status_q.size() == 0) begin
        report_mismatch("extra result", 1, 0);
      end else begin
        w = status_q.pop_front();
        if (out_running_slot !== w.slot) report_mismatch("slot", out_running_slot, w.slot);
        if (out_running_idle !== w.idle) report_mismatch("idle", out_running_idle, w.idle);
        if (out_new_task_id !== w.ident) report_mismatch("id", out_new_task_id, w.ident);
        if (out_error_code !== w.err) report_mismatch("err", out_error_code, w.err);
      end
    end
  end

  task automatic test_before_start();
    send_request(tsch_pkg::ACT_TICK);
    send_request(tsch_pkg::ACT_YIELD);
    send_request(tsch_pkg::ACT_TERM);
    send_request(tsch_pkg::ACT_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(tsch_pkg::ACT_CREATE_SYS, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(tsch_pkg::ACT_CREATE_PER, 16'd5, 16'd5, 16'd0);
    send_request(tsch_pkg::ACT_CREATE_PER, 16'hFFFF, 16'hFFFE, 16'h0000);
    send_request(tsch_pkg::ACT_CREATE_PER, 16'd10, 16'd0, 16'd2);
    send_request(tsch_pkg::ACT_CREATE_RR);
  endtask

  task automatic test_start_and_run();
    send_request(tsch_pkg::ACT_START);
    send_request(tsch_pkg::ACT_TICK);
    send_request(tsch_pkg::ACT_YIELD);
    send_request(tsch_pkg::ACT_TERM);
    send_request(tsch_pkg::ACT_START);
    repeat (3) send_request(tsch_pkg::ACT_TICK);
    send_request(tsch_pkg::ACT_YIELD);
    send_request(tsch_pkg::ACT_TERM);
    send_request(tsch_pkg::ACT_TERM);
    send_request(tsch_pkg::ACT_TERM);
    send_request(tsch_pkg::ACT_TERM);
  endtask

  task automatic test_table_full();
    for (int i = 0; i < tsch_pkg::MAX_TASKS + 2; i++) send_request(tsch_pkg::ACT_CREATE_RR);
    send_request(tsch_pkg::ACT_CREATE_PER, 16'd3, 16'd3, 16'd0);
  endtask

  task automatic test_random(int n);
    logic [2:0] a;
    logic [15:0] p;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 3) a = tsch_pkg::ACT_START;
      else if (k < 6) a = tsch_pkg::ACT_NONE;
      else if (k < 12) a = tsch_pkg::ACT_CREATE_SYS;
      else if (k < 24) a = tsch_pkg::ACT_CREATE_PER;
      else if (k < 32) a = tsch_pkg::ACT_CREATE_RR;
      else if (k < 65) a = tsch_pkg::ACT_TICK;
      else if (k < 82) a = tsch_pkg::ACT_YIELD;
      else a = tsch_pkg::ACT_TERM;
      // mostly short periods so releases come round; a few full-range ones
      if ($urandom_range(0, 9) == 0) begin
        p = 16'($urandom);
        send_request(a, p, 16'($urandom), 16'($urandom));
      end else begin
        p = 16'($urandom_range(1, 24));
        send_request(a, p, 16'($urandom_range(0, p)), 16'(sh_tick + $urandom_range(0, 20)));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_before_start();
    test_start_and_run();
    test_table_full();
    test_random(1520);
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("tb_three_class_task_scheduler passed");
    else
      $display("tb_three_class_task_scheduler failed");
    $finish;
  end

  initial begin
    #5000000;
    $display("tb_three_class_task_scheduler failed");
    $finish;
  end
endmodule
